// ===== hw/rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master byte engine: command codes,
// register indexes, reset values and the engine state record.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

   typedef enum logic [2:0] {
      CMD_IDLE      = 3'd0,
      CMD_START     = 3'd1,
      CMD_STOP      = 3'd2,
      CMD_WRITE     = 3'd3,
      CMD_READ_ACK  = 3'd4,
      CMD_READ_NACK = 3'd5
   } cmd_type;

   localparam logic [1:0] REG_PHASE_TICKS    = 2'd0;
   localparam logic [1:0] REG_ACK_WAIT_LIMIT = 2'd1;

   localparam logic [15:0] PHASE_TICKS_RESET    = 16'd5;
   localparam logic [7:0]  ACK_WAIT_LIMIT_RESET = 8'd200;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef struct packed {
      logic [15:0] phase_ticks;
      logic [7:0]  ack_wait_limit;
   } cfg_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [3:0]  step;
      logic [3:0]  bit_idx;
      logic [7:0]  shift;
      logic [15:0] tick_cnt;
      logic [7:0]  poll_cnt;
      logic        scl;
      logic        sda;
      logic        err;
      logic [7:0]  rx;
   } state_type;

   localparam state_type STATE_RESET = '{
      cmd:      CMD_IDLE,
      step:     4'd0,
      bit_idx:  4'd0,
      shift:    8'd0,
      tick_cnt: 16'd0,
      poll_cnt: 8'd0,
      scl:      1'b1,
      sda:      1'b1,
      err:      1'b0,
      rx:       8'd0
   };

endpackage

`default_nettype wire

// ===== hw/rtl/i2cm_step.sv =====
// ----------------------------------------------------------------------------
// i2cm_step
// Next-state logic of the bus engine for one timing tick: command take-over,
// phase timing, bit shifting, acknowledge polling and line levels.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_step (
   input  var i2cm_pkg::state_type st,
   input  var i2cm_pkg::cfg_type   cfg,
   input  wire logic [2:0]         operation,
   input  wire logic [7:0]         tx_byte,
   input  wire logic               sda_in,
   output i2cm_pkg::state_type     nx,
   output logic                    done
);
   import i2cm_pkg::*;

   // generic phase steps
   localparam logic [3:0] P_FIRST  = 4'd0;
   localparam logic [3:0] P_SECOND = 4'd1;
   localparam logic [3:0] P_THIRD  = 4'd2;
   // write phases
   localparam logic [3:0] W_BIT_LOW  = 4'd0;
   localparam logic [3:0] W_BIT_HIGH = 4'd1;
   localparam logic [3:0] W_BIT_END  = 4'd2;
   localparam logic [3:0] W_ACK_REL  = 4'd3;
   localparam logic [3:0] W_ACK_HIGH = 4'd4;
   localparam logic [3:0] W_ACK_POLL = 4'd5;
   localparam logic [3:0] W_STOP_LOW = 4'd6;
   localparam logic [3:0] W_STOP_SCL = 4'd7;
   localparam logic [3:0] W_STOP_SDA = 4'd8;
   // read phases
   localparam logic [3:0] R_BIT_LOW  = 4'd0;
   localparam logic [3:0] R_BIT_HIGH = 4'd1;
   localparam logic [3:0] R_ACK_LOW  = 4'd2;
   localparam logic [3:0] R_ACK_HIGH = 4'd3;

   function automatic state_type enter_phase(input state_type s_in, input logic [3:0] s);
      state_type r;
      r = s_in;
      r.step = s;
      r.tick_cnt = '0;
      case (s_in.cmd)
         CMD_START: begin
            if (s == P_FIRST) begin
               r.scl = 1'b1;
               r.sda = 1'b1;
            end else begin
               r.sda = 1'b0;
            end
         end
         CMD_STOP: begin
            if (s == P_FIRST) begin
               r.scl = 1'b0;
               r.sda = 1'b0;
            end else if (s == P_SECOND) begin
               r.scl = 1'b1;
            end else begin
               r.sda = 1'b1;
            end
         end
         CMD_WRITE: begin
            case (s)
               W_BIT_LOW: begin
                  r.scl = 1'b0;
                  r.sda = s_in.shift[7];
               end
               W_BIT_HIGH: r.scl = 1'b1;
               W_BIT_END:  r.scl = 1'b0;
               W_ACK_REL: begin
                  r.scl = 1'b0;
                  r.sda = 1'b1;
               end
               W_ACK_HIGH: r.scl = 1'b1;
               W_STOP_LOW: begin
                  r.scl = 1'b0;
                  r.sda = 1'b0;
               end
               W_STOP_SCL: r.scl = 1'b1;
               W_STOP_SDA: r.sda = 1'b1;
               default: ;
            endcase
         end
         default: begin
            case (s)
               R_BIT_LOW: begin
                  r.scl = 1'b0;
                  r.sda = 1'b1;
               end
               R_BIT_HIGH: r.scl = 1'b1;
               R_ACK_LOW: begin
                  r.scl = 1'b0;
                  r.sda = (s_in.cmd == CMD_READ_ACK) ? 1'b0 : 1'b1;
               end
               R_ACK_HIGH: r.scl = 1'b1;
               default: ;
            endcase
         end
      endcase
      return r;
   endfunction

   logic [15:0] limit;
   logic [15:0] tick_inc;
   logic        over;

   always_comb begin
      nx = st;
      done = 1'b0;
      limit = (cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks;
      tick_inc = 16'd0;
      over = 1'b0;

      // take a command on an idle tick
      if (st.cmd == CMD_IDLE && operation >= 3'(CMD_START) &&
          operation <= 3'(CMD_READ_NACK)) begin
         nx.cmd = cmd_type'(operation);
         nx.bit_idx = '0;
         nx.poll_cnt = '0;
         if (cmd_type'(operation) == CMD_WRITE) begin
            nx.shift = tx_byte;
            nx.err = 1'b0;
         end else begin
            nx.shift = '0;
         end
         nx = enter_phase(nx, P_FIRST);
      end

      // phase timer, not used while polling for the acknowledge
      if (!(nx.cmd == CMD_WRITE && nx.step == W_ACK_POLL)) begin
         tick_inc = nx.tick_cnt + 16'd1;
         over = (tick_inc >= limit);
      end

      case (nx.cmd)
         CMD_START: begin
            nx.tick_cnt = tick_inc;
            if (over) begin
               if (nx.step == P_FIRST) begin
                  nx = enter_phase(nx, P_SECOND);
               end else begin
                  nx.scl = 1'b0;
                  nx.cmd = CMD_IDLE;
                  nx.step = '0;
                  nx.tick_cnt = '0;
                  done = 1'b1;
               end
            end
         end
         CMD_STOP: begin
            nx.tick_cnt = tick_inc;
            if (over) begin
               if (nx.step < P_THIRD) begin
                  nx = enter_phase(nx, nx.step + 4'd1);
               end else begin
                  nx.cmd = CMD_IDLE;
                  nx.step = '0;
                  nx.tick_cnt = '0;
                  done = 1'b1;
               end
            end
         end
         CMD_WRITE: begin
            if (nx.step == W_ACK_POLL) begin
               if (!sda_in) begin
                  nx.scl = 1'b0;
                  nx.cmd = CMD_IDLE;
                  nx.step = '0;
                  nx.tick_cnt = '0;
                  done = 1'b1;
               end else if (nx.poll_cnt >= cfg.ack_wait_limit) begin
                  nx.err = 1'b1;
                  nx = enter_phase(nx, W_STOP_LOW);
               end else begin
                  nx.poll_cnt = nx.poll_cnt + 8'd1;
               end
            end else begin
               nx.tick_cnt = tick_inc;
               if (over) begin
                  case (nx.step)
                     W_BIT_LOW:  nx = enter_phase(nx, W_BIT_HIGH);
                     W_BIT_HIGH: nx = enter_phase(nx, W_BIT_END);
                     W_BIT_END: begin
                        nx.shift = {nx.shift[6:0], 1'b0};
                        nx.bit_idx = nx.bit_idx + 4'd1;
                        nx = enter_phase(nx,
                           (nx.bit_idx < BITS_PER_BYTE) ? W_BIT_LOW : W_ACK_REL);
                     end
                     W_ACK_REL:  nx = enter_phase(nx, W_ACK_HIGH);
                     W_ACK_HIGH: begin
                        nx.poll_cnt = '0;
                        nx = enter_phase(nx, W_ACK_POLL);
                     end
                     W_STOP_LOW: nx = enter_phase(nx, W_STOP_SCL);
                     W_STOP_SCL: nx = enter_phase(nx, W_STOP_SDA);
                     default: begin
                        nx.cmd = CMD_IDLE;
                        nx.step = '0;
                        nx.tick_cnt = '0;
                        done = 1'b1;
                     end
                  endcase
               end
            end
         end
         CMD_READ_ACK, CMD_READ_NACK: begin
            nx.tick_cnt = tick_inc;
            if (over) begin
               case (nx.step)
                  R_BIT_LOW: nx = enter_phase(nx, R_BIT_HIGH);
                  R_BIT_HIGH: begin
                     nx.shift = {nx.shift[6:0], sda_in};
                     nx.bit_idx = nx.bit_idx + 4'd1;
                     nx = enter_phase(nx,
                        (nx.bit_idx < BITS_PER_BYTE) ? R_BIT_LOW : R_ACK_LOW);
                  end
                  R_ACK_LOW: nx = enter_phase(nx, R_ACK_HIGH);
                  default: begin
                     nx.scl = 1'b0;
                     nx.rx = nx.shift;
                     nx.cmd = CMD_IDLE;
                     nx.step = '0;
                     nx.tick_cnt = '0;
                     done = 1'b1;
                  end
               endcase
            end
         end
         default: nx.cmd = CMD_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/i2c_master_byte_engine_core.sv =====
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_core
// I2C master byte engine: start, stop, byte write with acknowledge wait and
// byte read with ACK or NACK, advanced one timing tick per request transfer.
// ----------------------------------------------------------------------------
// Each request transfer is one timing tick and yields exactly one response
// transfer holding the line levels and status after that tick. The engine
// state and the response are updated in the same cycle, so one tick is taken
// every clock cycle; the only thing that holds requests back is a response
// register that is full and not being taken. Commands arriving while busy
// are ignored. Registers: index 0 phase_ticks, index 1 ack_wait_limit; they
// are to be written only while the engine is idle; the core does not check.
`default_nettype none

module i2c_master_byte_engine_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: tdata = tx_byte[7:0], sda_in[8], zero pad
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,
   // request: tuser = operation[2:0]
   input  wire logic [2:0]  req_tuser,
   // response: tdata = scl_level[0], sda_drive[1], busy_res[2], done_res[3],
   //           rx_byte[11:4], ack_error[12], zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,
   // register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import i2cm_pkg::*;

   state_type   st_ff;
   state_type   st_in;
   cfg_type     cfg_ff;
   logic        done_in;
   logic        rsp_valid_ff;
   logic [15:0] rsp_data_ff;
   logic [15:0] rsp_data_in;
   logic        req_xfer;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   i2cm_step u_step (
      .st        (st_ff),
      .cfg       (cfg_ff),
      .operation (req_tuser),
      .tx_byte   (req_tdata[7:0]),
      .sda_in    (req_tdata[8]),
      .nx        (st_in),
      .done      (done_in)
   );

   assign rsp_data_in = {3'b000, st_in.err, st_in.rx, done_in,
                         (st_in.cmd != CMD_IDLE), st_in.sda, st_in.scl};

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= STATE_RESET;
         cfg_ff.phase_ticks <= PHASE_TICKS_RESET;
         cfg_ff.ack_wait_limit <= ACK_WAIT_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_PHASE_TICKS) begin
               cfg_ff.phase_ticks <= csr_data;
            end else if (csr_index == REG_ACK_WAIT_LIMIT) begin
               cfg_ff.ack_wait_limit <= csr_data[7:0];
            end
         end
         if (req_xfer) begin
            st_ff <= st_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // a completing tick never reports busy
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[3] |-> !rsp_data_ff[2])
      else $error("done reported together with busy");

   // idle engine holds a cleared phase timer
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      st_ff.cmd == CMD_IDLE |-> st_ff.tick_cnt == 16'd0 && st_ff.step == 4'd0)
      else $error("idle engine with running phase timer");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      st_ff.bit_idx <= BITS_PER_BYTE)
      else $error("bit index beyond a byte");

   // a held response blocks new request transfers
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("request taken while response is stalled");

   a_err_in_write: assert property (@(posedge clock) disable iff (reset)
      $rose(st_ff.err) |-> st_ff.cmd == CMD_WRITE)
      else $error("acknowledge error raised outside a write");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the I2C master byte engine core. Every request
// transfer is one timing tick; a local model of the engine predicts the
// line levels and status for each accepted tick, and every response
// transfer is compared field by field. A directed table runs first, then
// random command sequences under several register settings with bursty
// requests, receiver stalls and one long phase at the largest phase length.
// ----------------------------------------------------------------------------

module testbench;
   import i2cm_pkg::*;

   localparam int         CYCLE_LIMIT = 5_000_000;
   localparam logic [2:0] OP_SPARE_6  = 3'd6;
   localparam logic [2:0] OP_SPARE_7  = 3'd7;
   localparam logic [8:0] NEVER_ACK   = 9'd256;

   typedef struct packed {
      logic       ack_error;
      logic [7:0] rx_byte;
      logic       done;
      logic       busy;
      logic       sda_drive;
      logic       scl_level;
   } line_status_t;

   typedef struct packed {
      logic [2:0]   op;
      logic [7:0]   tx;
      logic [7:0]   rx_bits;
      logic [8:0]   ack_delay;
      logic         fixed;
      line_status_t fixed_status;
   } script_row_t;

   localparam line_status_t IDLE_STATUS = '{1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1};

   // rows before ROWS_AT_RESET run with the reset register values
   localparam int ROWS_AT_RESET = 5;
   localparam int SCRIPT_ROWS   = 17;
   localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
      '{CMD_IDLE,      8'h00, 8'h00, 9'd0,      1'b1, IDLE_STATUS},
      '{OP_SPARE_6,    8'hFF, 8'h00, 9'd0,      1'b1, IDLE_STATUS},
      '{OP_SPARE_7,    8'h5A, 8'h00, 9'd0,      1'b1, IDLE_STATUS},
      '{CMD_START,     8'h00, 8'h00, 9'd0,      1'b0, '0},
      '{CMD_WRITE,     8'h96, 8'h00, 9'd2,      1'b0, '0},
      '{CMD_WRITE,     8'hFF, 8'h00, 9'd0,      1'b0, '0},
      // no acknowledge: timeout, stop sequence, both lines released
      '{CMD_WRITE,     8'h00, 8'h00, NEVER_ACK, 1'b1, '{1'b1, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1}},
      '{CMD_READ_ACK,  8'h00, 8'hFF, 9'd0,      1'b1, '{1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0}},
      '{CMD_READ_NACK, 8'hFF, 8'h00, 9'd0,      1'b1, '{1'b1, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0}},
      '{CMD_WRITE,     8'hA5, 8'h00, 9'd0,      1'b0, '0},
      '{CMD_STOP,      8'h00, 8'h00, 9'd0,      1'b0, '0},
      '{CMD_READ_NACK, 8'h00, 8'h5A, 9'd0,      1'b0, '0},
      '{CMD_WRITE,     8'h01, 8'h00, 9'd1,      1'b0, '0},
      '{CMD_START,     8'h00, 8'h00, 9'd0,      1'b0, '0},
      '{CMD_WRITE,     8'h80, 8'h00, 9'd0,      1'b0, '0},
      '{CMD_READ_ACK,  8'h00, 8'hC3, 9'd0,      1'b0, '0},
      '{CMD_STOP,      8'h00, 8'h00, 9'd0,      1'b0, '0}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // tx_byte[7:0], sda_in[8], zero pad
   logic [2:0]  req_tuser  = '0;   // operation[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // scl, sda, busy, done, rx_byte[11:4], ack_error[12]
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = '0;
   logic [15:0] csr_data   = '0;

   always #2 clock = ~clock;

   i2c_master_byte_engine_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // engine model state and register copies
   cmd_type     eng_cmd;
   logic [5:0]  eng_step;
   logic [3:0]  eng_bit;
   logic [7:0]  eng_shift;
   logic [15:0] eng_ticks;
   logic [7:0]  eng_polls;
   logic        eng_scl;
   logic        eng_sda;
   logic        eng_err;
   logic [7:0]  eng_rx;
   logic        eng_done;
   logic [15:0] cfg_phase_ticks;
   logic [7:0]  cfg_ack_limit;

   line_status_t expected_status_q [$];

   int fail_count        = 0;
   int responses_checked = 0;
   int items_sent        = 0;
   int ack_timeouts      = 0;
   int bytes_read        = 0;
   int cmd_count [8]     = '{default: 0};
   int cycle_count       = 0;
   int burst_left        = 0;
   int gap_left          = 0;
   int hold_request      = 0;
   int hold_left         = 0;
   int stall_mode        = 0;
   int mode_left         = 0;

   function automatic void engine_reset();
      cfg_phase_ticks = PHASE_TICKS_RESET;
      cfg_ack_limit   = ACK_WAIT_LIMIT_RESET;
      eng_cmd   = CMD_IDLE;
      eng_step  = '0;
      eng_bit   = '0;
      eng_shift = '0;
      eng_ticks = '0;
      eng_polls = '0;
      eng_scl   = 1'b1;
      eng_sda   = 1'b1;
      eng_err   = 1'b0;
      eng_rx    = '0;
      eng_done  = 1'b0;
   endfunction

   function automatic void open_phase(logic [5:0] s);
      eng_step  = s;
      eng_ticks = '0;
      case (eng_cmd)
         CMD_START: begin
            if (s == 6'd0) begin
               eng_scl = 1'b1;
               eng_sda = 1'b1;
            end else begin
               eng_sda = 1'b0;
            end
         end
         CMD_STOP: begin
            if (s == 6'd0) begin
               eng_scl = 1'b0;
               eng_sda = 1'b0;
            end else if (s == 6'd1) begin
               eng_scl = 1'b1;
            end else begin
               eng_sda = 1'b1;
            end
         end
         CMD_WRITE: begin
            case (s)
               6'd0: begin
                  eng_scl = 1'b0;
                  eng_sda = eng_shift[7];
               end
               6'd1, 6'd4, 6'd7: eng_scl = 1'b1;
               6'd2: eng_scl = 1'b0;
               6'd3: begin
                  eng_scl = 1'b0;
                  eng_sda = 1'b1;
               end
               6'd6: begin
                  eng_scl = 1'b0;
                  eng_sda = 1'b0;
               end
               6'd8: eng_sda = 1'b1;
               default: ;
            endcase
         end
         default: begin
            case (s)
               6'd0: begin
                  eng_scl = 1'b0;
                  eng_sda = 1'b1;
               end
               6'd1, 6'd3: eng_scl = 1'b1;
               6'd2: begin
                  eng_scl = 1'b0;
                  eng_sda = (eng_cmd == CMD_READ_ACK) ? 1'b0 : 1'b1;
               end
               default: ;
            endcase
         end
      endcase
   endfunction

   function automatic logic phase_expired();
      logic [15:0] span;
      span = (cfg_phase_ticks == 16'd0) ? 16'd1 : cfg_phase_ticks;
      eng_ticks = eng_ticks + 16'd1;
      return eng_ticks >= span;
   endfunction

   function automatic void close_command();
      eng_cmd   = CMD_IDLE;
      eng_step  = '0;
      eng_ticks = '0;
      eng_done  = 1'b1;
   endfunction

   function automatic void write_tick(logic sda);
      if (eng_step == 6'd5) begin
         if (!sda) begin
            eng_scl = 1'b0;
            close_command();
         end else if (eng_polls >= cfg_ack_limit) begin
            eng_err = 1'b1;
            ack_timeouts++;
            open_phase(6'd6);
         end else begin
            eng_polls = eng_polls + 8'd1;
         end
         return;
      end
      if (!phase_expired())
         return;
      case (eng_step)
         6'd0, 6'd1, 6'd3, 6'd6, 6'd7: open_phase(eng_step + 6'd1);
         6'd2: begin
            eng_shift = eng_shift << 1;
            eng_bit   = eng_bit + 4'd1;
            open_phase(eng_bit < BITS_PER_BYTE ? 6'd0 : 6'd3);
         end
         6'd4: begin
            eng_polls = '0;
            open_phase(6'd5);
         end
         default: close_command();
      endcase
   endfunction

   function automatic void read_tick(logic sda);
      if (!phase_expired())
         return;
      case (eng_step)
         6'd0, 6'd2: open_phase(eng_step + 6'd1);
         6'd1: begin
            eng_shift = {eng_shift[6:0], sda};
            eng_bit   = eng_bit + 4'd1;
            open_phase(eng_bit < BITS_PER_BYTE ? 6'd0 : 6'd2);
         end
         default: begin
            eng_scl = 1'b0;
            eng_rx  = eng_shift;
            bytes_read++;
            close_command();
         end
      endcase
   endfunction

   function automatic line_status_t engine_tick(logic [2:0] op, logic [7:0] tx, logic sda);
      line_status_t status;
      eng_done = 1'b0;
      if (eng_cmd == CMD_IDLE && op >= CMD_START && op <= CMD_READ_NACK) begin
         eng_cmd   = cmd_type'(op);
         eng_bit   = '0;
         eng_polls = '0;
         if (op == CMD_WRITE) begin
            eng_shift = tx;
            eng_err   = 1'b0;
         end else begin
            eng_shift = '0;
         end
         open_phase(6'd0);
      end
      case (eng_cmd)
         CMD_START: begin
            if (phase_expired()) begin
               if (eng_step == 6'd0) begin
                  open_phase(6'd1);
               end else begin
                  eng_scl = 1'b0;
                  close_command();
               end
            end
         end
         CMD_STOP: begin
            if (phase_expired()) begin
               if (eng_step < 6'd2) open_phase(eng_step + 6'd1);
               else close_command();
            end
         end
         CMD_WRITE: write_tick(sda);
         CMD_READ_ACK, CMD_READ_NACK: read_tick(sda);
         default: ;
      endcase
      status.ack_error = eng_err;
      status.rx_byte   = eng_rx;
      status.done      = eng_done;
      status.busy      = (eng_cmd != CMD_IDLE);
      status.sda_drive = eng_sda;
      status.scl_level = eng_scl;
      return status;
   endfunction

   // slave behaviour: data bits on the sampling tick, acknowledge after a number of polls
   function automatic logic pick_sda(logic [7:0] rx_bits, logic [8:0] ack_delay);
      logic [15:0] span;
      span = (cfg_phase_ticks == 16'd0) ? 16'd1 : cfg_phase_ticks;
      if ((eng_cmd == CMD_READ_ACK || eng_cmd == CMD_READ_NACK) && eng_step == 6'd1
          && 16'(eng_ticks + 16'd1) >= span)
         return rx_bits[3'(4'd7 - eng_bit)];
      if (eng_cmd == CMD_WRITE && eng_step == 6'd5)
         return ({1'b0, eng_polls} >= ack_delay) ? 1'b0 : 1'b1;
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic send_tick(input logic [2:0] op, input logic [7:0] tx, input logic sda,
                            input logic fixed, input line_status_t fixed_status);
      line_status_t predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      end
      while (gap_left > 0) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         gap_left--;
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, sda, tx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = engine_tick(op, tx, sda);
      expected_status_q.push_back((fixed && !predicted.busy) ? fixed_status : predicted);
      items_sent++;
   endtask

   task automatic run_command(input logic [2:0] op, input logic [7:0] tx,
                              input logic [7:0] rx_bits, input logic [8:0] ack_delay,
                              input int noise_pct, input logic fixed,
                              input line_status_t fixed_status);
      logic [2:0] tick_op;
      cmd_count[op]++;
      send_tick(op, tx, pick_sda(rx_bits, ack_delay), fixed, fixed_status);
      while (eng_cmd != CMD_IDLE) begin
         // commands offered while busy must be ignored
         tick_op = ($urandom_range(0, 99) < noise_pct) ? 3'($urandom_range(0, 7)) : CMD_IDLE;
         send_tick(tick_op, 8'($urandom), pick_sda(rx_bits, ack_delay), fixed, fixed_status);
      end
   endtask

   task automatic random_command();
      logic [2:0] op;
      logic [8:0] delay;
      int         pick;
      if ($urandom_range(0, 6) == 0) begin
         repeat ($urandom_range(1, 4)) begin
            pick = $urandom_range(0, 2);
            op   = (pick == 0) ? CMD_IDLE : (pick == 1) ? OP_SPARE_6 : OP_SPARE_7;
            send_tick(op, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
         end
      end
      pick = $urandom_range(0, 9);
      if (pick < 4)
         delay = 9'($urandom_range(0, 3));
      else if (pick < 7)
         delay = 9'($urandom_range(0, cfg_ack_limit));
      else if (pick < 8)
         delay = {1'b0, cfg_ack_limit} + 9'($urandom_range(0, 1));
      else
         delay = NEVER_ACK;
      run_command(3'($urandom_range(CMD_START, CMD_READ_NACK)), 8'($urandom),
                  8'($urandom), delay, 10, 1'b0, '0);
   endtask

   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      while (expected_status_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      wait_for_responses();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == REG_PHASE_TICKS)
         cfg_phase_ticks = value;
      else if (idx == REG_ACK_WAIT_LIMIT)
         cfg_ack_limit = value[7:0];
   endtask

   task automatic random_phase(input logic [15:0] ticks, input logic [7:0] ack_limit,
                               input int n_items);
      int phase_end;
      write_reg(REG_PHASE_TICKS, ticks);
      write_reg(REG_ACK_WAIT_LIMIT, {8'd0, ack_limit});
      phase_end = items_sent + n_items;
      while (items_sent < phase_end) random_command();
   endtask

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   // receiver: changing stall pattern, plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_request > 0) begin
         hold_left    = hold_request - 1;
         hold_request = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(32, 200);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ~rsp_tready;
         endcase
      end
   end

   always @(posedge clock) begin : check_responses
      line_status_t got;
      line_status_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = line_status_t'(rsp_tdata[12:0]);
         if (expected_status_q.size() == 0) begin
            $error("response transfer with nothing expected: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = expected_status_q.pop_front();
            responses_checked++;
            compare_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
            compare_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
            compare_field("busy_res",  8'(want.busy),      8'(got.busy));
            compare_field("done_res",  8'(want.done),      8'(got.done));
            compare_field("rx_byte",   want.rx_byte,       got.rx_byte);
            compare_field("ack_error", 8'(want.ack_error), 8'(got.ack_error));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_status_q.size());
         $display("i2c_master_byte_engine_core: mismatch");
         $finish;
      end
   end

   initial begin
      engine_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         // zero phase length and zero poll allowance from here on
         if (i == ROWS_AT_RESET) begin
            write_reg(REG_PHASE_TICKS, 16'd0);
            write_reg(REG_ACK_WAIT_LIMIT, 16'd0);
         end
         run_command(SCRIPT[i].op, SCRIPT[i].tx, SCRIPT[i].rx_bits, SCRIPT[i].ack_delay, 0,
                     SCRIPT[i].fixed, SCRIPT[i].fixed_status);
      end

      write_reg(REG_PHASE_TICKS, 16'd1);
      write_reg(REG_ACK_WAIT_LIMIT, 16'd3);
      // long receiver hold while requests keep coming
      hold_request = 150;
      while (items_sent < 400) random_command();

      random_phase(16'd2, 8'd255, 180);
      // sender waits for every outstanding response
      wait_for_responses();
      while (items_sent < 700) random_command();

      random_phase(16'd3, 8'd1, 300);

      // longest phase length: the opening ticks of a start condition
      write_reg(REG_PHASE_TICKS, 16'hFFFF);
      write_reg(REG_ACK_WAIT_LIMIT, 16'd128);
      cmd_count[CMD_START]++;
      send_tick(CMD_START, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
      repeat (40) send_tick(CMD_IDLE, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);

      wait_for_responses();
      repeat (8) @(posedge clock);

      $display("ran %0d ticks: %0d start, %0d stop, %0d write, %0d read commands",
               items_sent, cmd_count[CMD_START], cmd_count[CMD_STOP], cmd_count[CMD_WRITE],
               cmd_count[CMD_READ_ACK] + cmd_count[CMD_READ_NACK]);
      $display("%0d responses checked, %0d acknowledge timeouts, %0d bytes read",
               responses_checked, ack_timeouts, bytes_read);
      if (fail_count == 0) begin
         $display("i2c_master_byte_engine_core: match");
      end else begin
         $display("i2c_master_byte_engine_core: mismatch");
      end
      $finish;
   end

endmodule
